>>> hw/rtl/elr_pkg.sv
// ----------------------------------------------------------------------------
// elr_pkg
// shared types, character codes and result tables of the echoing line receiver
// ----------------------------------------------------------------------------
package elr_pkg;

    typedef enum logic [2:0] {
        KIND_READ,
        KIND_PLAIN,
        KIND_CR,
        KIND_BS,
        KIND_OVF
    } t_kind;

    typedef enum logic [1:0] {
        EV_NONE,
        EV_LINE,
        EV_KEYWORD,
        EV_OVERFLOW
    } t_event;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] rx_byte;
        t_event     evt;
        logic [7:0] line_len;
    } t_bundle;

    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [2:0] KEY_LAST = 3'd5;

    // keyword CLIENT, one char per position
    function automatic logic [7:0] key_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h43;
            3'd1:    c = 8'h4C;
            3'd2:    c = 8'h49;
            3'd3:    c = 8'h45;
            3'd4:    c = 8'h4E;
            3'd5:    c = 8'h54;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] result_count(input t_kind kind);
        logic [2:0] n;
        case (kind)
            KIND_READ:  n = 3'd1;
            KIND_PLAIN: n = 3'd1;
            KIND_CR:    n = 3'd2;
            KIND_BS:    n = 3'd3;
            KIND_OVF:   n = 3'd5;
            default:    n = 3'd1;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] result_byte(input t_kind kind, input logic [2:0] pos,
                                               input logic [7:0] rx);
        logic [7:0] c;
        if (kind == KIND_READ) begin
            c = 8'h00;
        end else if (pos == 3'd0) begin
            c = rx;
        end else begin
            case (kind)
                KIND_CR:  c = CH_LF;
                KIND_BS:  c = (pos == 3'd1) ? CH_SP : CH_BS;
                KIND_OVF: c = (pos == 3'd1) ? CH_CR : CH_LF;
                default:  c = 8'h00;
            endcase
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/echoing_line_receiver.sv
// ----------------------------------------------------------------------------
// echoing_line_receiver
// terminal line editor: echoes received bytes, edits a line store, reports
// line end, keyword and overflow events, and reads back stored bytes
// ----------------------------------------------------------------------------
// flow: an accepted input word waits in the input register until the result
//   register is free; that register sends its 1 to 5 result words in order, one
//   per cycle while m_axis_tready is high, and takes the next word with the last
// reset: synchronous, clears fill count and pipeline, capacity back to 256;
//   the line store is not cleared
module echoing_line_receiver #(
    parameter int LINE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // rx_byte, read_index
    input  logic        s_axis_tuser,   // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // out_byte, event_res, line_length, read_data
    output logic        m_axis_tuser,   // echo_valid
    output logic        m_axis_tlast,   // last
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import elr_pkg::*;

    logic       r_in_valid;
    logic       r_in_op;
    logic [7:0] r_in_byte;
    logic [7:0] r_in_idx;
    logic [8:0] r_capacity;

    logic       take;
    logic       ser_free;
    t_bundle    bundle;
    logic [7:0] rdata;
    logic [7:0] fill;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {23'd0, r_capacity};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= 9'd256;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_capacity <= pwdata[8:0];
        end
    end

    assign take          = r_in_valid && ser_free;
    assign s_axis_tready = !r_in_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_op   <= s_axis_tuser;
            r_in_byte <= s_axis_tdata[7:0];
            r_in_idx  <= s_axis_tdata[15:8];
        end
    end

    elr_core #(
        .LINE_DEPTH(LINE_DEPTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_op         (r_in_op),
        .i_rx_byte    (r_in_byte),
        .i_read_index (r_in_idx),
        .i_capacity   (r_capacity),
        .o_bundle     (bundle),
        .o_rdata      (rdata),
        .o_fill       (fill)
    );

    elr_serializer u_ser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (take),
        .i_bundle      (bundle),
        .i_rdata       (rdata),
        .o_free        (ser_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    a_event_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[9:8] != 2'd0 |-> m_axis_tlast)
        else $error("event on a non-final result word");

    a_read_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
        else $error("read result is not a single final word");

    a_event_clears_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && bundle.evt != EV_NONE |=> fill == 8'd0)
        else $error("fill count not cleared after an event");

    a_take_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> m_axis_tvalid)
        else $error("taken item produced no result word");

endmodule

>>> hw/rtl/elr_core.sv
// ----------------------------------------------------------------------------
// elr_core
// line store, fill count and keyword tracking; decides the results of one word
// ----------------------------------------------------------------------------
module elr_core #(
    parameter int LINE_DEPTH = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic              i_op,
    input  logic [7:0]        i_rx_byte,
    input  logic [7:0]        i_read_index,
    input  logic [8:0]        i_capacity,
    output elr_pkg::t_bundle  o_bundle,
    output logic [7:0]        o_rdata,
    output logic [7:0]        o_fill
);
    import elr_pkg::*;

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int XW = (AW > 8) ? AW : 8;
    localparam logic [8:0] DEPTH_CAP = (LINE_DEPTH > 256) ? 9'd256 : 9'(LINE_DEPTH);

    logic [7:0] r_store [LINE_DEPTH];
    logic [2:0] r_kmap  [LINE_DEPTH];
    logic [7:0] r_fill;
    logic [2:0] r_ktop;
    logic [7:0] r_rdata;

    logic [8:0]    cap_c;
    logic [7:0]    limit;
    logic [7:0]    n_fill;
    logic [2:0]    n_k;
    logic          wr;
    t_kind         kind;
    t_event        evt;
    logic [7:0]    len;
    logic [7:0]    eff_fill;
    logic [7:0]    kidx;
    logic [XW-1:0] fill_x;
    logic [XW-1:0] rd_x;
    logic [XW-1:0] k_x;
    logic [AW-1:0] fill_addr;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] k_addr;
    logic          oor;

    always_comb begin
        cap_c = (i_capacity == 9'd0) ? 9'd1 : i_capacity;
        if (cap_c > DEPTH_CAP) begin
            cap_c = DEPTH_CAP;
        end
        limit = 8'(cap_c - 9'd1);

        n_fill = r_fill;
        n_k    = 3'd0;
        wr     = 1'b0;
        kind   = KIND_PLAIN;
        evt    = EV_NONE;
        len    = 8'd0;

        if (i_op) begin
            kind = KIND_READ;
        end else begin
            case (i_rx_byte)
                CH_CR: begin
                    kind = KIND_CR;
                    evt  = EV_LINE;
                end
                CH_BS: begin
                    if (r_fill != 8'd0) begin
                        kind   = KIND_BS;
                        n_fill = r_fill - 8'd1;
                    end
                end
                default: begin
                    if (r_fill < limit) begin
                        wr     = 1'b1;
                        n_fill = r_fill + 8'd1;
                        if (i_rx_byte == key_char(r_ktop)) begin
                            n_k = r_ktop + 3'd1;
                        end else if (i_rx_byte == key_char(3'd0)) begin
                            n_k = 3'd1;
                        end
                        if (r_ktop == KEY_LAST && i_rx_byte == key_char(KEY_LAST)) begin
                            evt = EV_KEYWORD;
                        end
                    end else begin
                        kind = KIND_OVF;
                        evt  = EV_OVERFLOW;
                    end
                end
            endcase
        end

        if (evt != EV_NONE) begin
            len    = n_fill;
            n_fill = 8'd0;
        end

        eff_fill = i_take ? n_fill : r_fill;
        kidx     = eff_fill - 8'd1;
        fill_x   = XW'(r_fill);
        rd_x     = XW'(i_read_index);
        k_x      = XW'(kidx);
        fill_addr = fill_x[AW-1:0];
        rd_addr   = rd_x[AW-1:0];
        k_addr    = k_x[AW-1:0];
        oor       = {1'b0, i_read_index} >= DEPTH_CAP;
    end

    always_ff @(posedge i_clk) begin
        if (i_take && wr) begin
            r_store[fill_addr] <= i_rx_byte;
            r_kmap[fill_addr]  <= n_k;
        end
        if (i_take && i_op) begin
            r_rdata <= oor ? 8'd0 : r_store[rd_addr];
        end
    end

    // match depth of the newest stored char, bypassed on a write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= 8'd0;
            r_ktop <= 3'd0;
        end else begin
            if (i_take) begin
                r_fill <= n_fill;
            end
            if (eff_fill == 8'd0) begin
                r_ktop <= 3'd0;
            end else if (i_take && wr) begin
                r_ktop <= n_k;
            end else begin
                r_ktop <= r_kmap[k_addr];
            end
        end
    end

    assign o_bundle.kind     = kind;
    assign o_bundle.rx_byte  = i_rx_byte;
    assign o_bundle.evt      = evt;
    assign o_bundle.line_len = len;
    assign o_rdata           = r_rdata;
    assign o_fill            = r_fill;

endmodule

>>> hw/rtl/elr_serializer.sv
// ----------------------------------------------------------------------------
// elr_serializer
// result register; sends the one to five result words of an item in order
// ----------------------------------------------------------------------------
module elr_serializer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  elr_pkg::t_bundle  i_bundle,
    input  logic [7:0]        i_rdata,
    output logic              o_free,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata,  // out_byte, event_res, line_length, read_data
    output logic              m_axis_tuser,  // echo_valid
    output logic              m_axis_tlast
);
    import elr_pkg::*;

    logic       r_valid;
    t_bundle    r_bundle;
    logic [2:0] r_idx;

    logic       last;
    logic [7:0] out_byte;
    logic [1:0] ev_bits;
    logic [7:0] len;
    logic [7:0] rdata;

    always_comb begin
        last     = (r_idx == result_count(r_bundle.kind) - 3'd1);
        out_byte = result_byte(r_bundle.kind, r_idx, r_bundle.rx_byte);
        ev_bits  = last ? r_bundle.evt : EV_NONE;
        len      = last ? r_bundle.line_len : 8'd0;
        rdata    = (r_bundle.kind == KIND_READ) ? i_rdata : 8'd0;
        o_free   = !r_valid || (m_axis_tready && last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= 3'd0;
        end else if (r_valid && m_axis_tready) begin
            if (last) begin
                r_valid <= 1'b0;
                r_idx   <= 3'd0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bundle <= i_bundle;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {6'd0, rdata, len, ev_bits, out_byte};
    assign m_axis_tuser  = (r_bundle.kind != KIND_READ);
    assign m_axis_tlast  = last;

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the echoing line receiver: a directed table of words
// (keyword, backspace, line end, overflow at small capacities, a capacity above the
// store depth) then random well-formed lines, reads and noise; every output word is
// compared with a line-editor predictor kept in step with each accepted input word
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import elr_pkg::*;

    localparam int          DEPTH         = 256;
    localparam int          WATCHDOG_MAX  = 2000;
    localparam logic [2:0]  ADDR_LINE_CAP = 3'd0;
    localparam logic        OP_RX         = 1'b0;
    localparam logic        OP_READ       = 1'b1;
    localparam logic [47:0] KEYWORD       = "CLIENT";

    typedef enum logic [1:0] {
        ROW_RX,
        ROW_READ,
        ROW_CAP
    } t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        logic [8:0] val;    // rx byte or capacity
        logic [7:0] idx;
        logic       typed;
        t_event     evt;
        logic [7:0] len;
    } t_row;

    typedef struct packed {
        logic       echo_valid;
        logic [7:0] out_byte;
        t_event     evt;
        logic [7:0] line_len;
        logic [7:0] read_data;
        logic       last;
    } t_word;

    localparam int PLAN_LEN = 30;
    localparam t_row PLAN [0:PLAN_LEN-1] = '{
        '{ROW_RX,   9'h043, 8'hFF, 1'b0, EV_NONE,     8'd0},
        '{ROW_RX,   9'h04C, 8'h00, 1'b0, EV_NONE,     8'd0},
        '{ROW_RX,   9'h049, 8'hFF, 1'b0, EV_NONE,     8'd0},
        '{ROW_RX,   9'h045, 8'h00, 1'b0, EV_NONE,     8'd0},
        '{ROW_RX,   9'h04E, 8'hFF, 1'b0, EV_NONE,     8'd0},
        '{ROW_RX,   9'h054, 8'h00, 1'b1, EV_KEYWORD,  8'd6},
        '{ROW_READ, 9'h0FF, 8'h00, 1'b0, EV_NONE,     8'd0},
        // backspace on an empty line
        '{ROW_RX,   9'h008, 8'hFF, 1'b1, EV_NONE,     8'd0},
        '{ROW_RX,   9'h000, 8'h00, 1'b1, EV_NONE,     8'd0},
        '{ROW_RX,   9'h0FF, 8'hFF, 1'b1, EV_NONE,     8'd0},
        '{ROW_RX,   9'h008, 8'h00, 1'b1, EV_NONE,     8'd0},
        '{ROW_RX,   9'h00D, 8'hFF, 1'b1, EV_LINE,     8'd1},
        // keyword finished after an edit
        '{ROW_RX,   9'h043, 8'h00, 1'b0, EV_NONE,     8'd0},
        '{ROW_RX,   9'h04C, 8'hFF, 1'b0, EV_NONE,     8'd0},
        '{ROW_RX,   9'h049, 8'h00, 1'b0, EV_NONE,     8'd0},
        '{ROW_RX,   9'h045, 8'hFF, 1'b0, EV_NONE,     8'd0},
        '{ROW_RX,   9'h04E, 8'h00, 1'b0, EV_NONE,     8'd0},
        '{ROW_RX,   9'h058, 8'hFF, 1'b0, EV_NONE,     8'd0},
        '{ROW_RX,   9'h008, 8'h00, 1'b0, EV_NONE,     8'd0},
        '{ROW_RX,   9'h054, 8'hFF, 1'b1, EV_KEYWORD,  8'd6},
        '{ROW_READ, 9'h000, 8'h05, 1'b0, EV_NONE,     8'd0},
        '{ROW_CAP,  9'd1,   8'h00, 1'b0, EV_NONE,     8'd0},
        '{ROW_RX,   9'h07A, 8'h00, 1'b1, EV_OVERFLOW, 8'd0},
        // capacity zero acts as one
        '{ROW_CAP,  9'd0,   8'h00, 1'b0, EV_NONE,     8'd0},
        '{ROW_RX,   9'h071, 8'hFF, 1'b1, EV_OVERFLOW, 8'd0},
        '{ROW_CAP,  9'd2,   8'h00, 1'b0, EV_NONE,     8'd0},
        '{ROW_RX,   9'h061, 8'h00, 1'b1, EV_NONE,     8'd0},
        '{ROW_RX,   9'h062, 8'hFF, 1'b1, EV_OVERFLOW, 8'd1},
        // capacity above the store depth
        '{ROW_CAP,  9'h1FF, 8'h00, 1'b0, EV_NONE,     8'd0},
        '{ROW_RX,   9'h00D, 8'h00, 1'b1, EV_LINE,     8'd0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;     // rx_byte, read_index
    logic        s_axis_tuser = 1'b0;   // operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // out_byte, event_res, line_length, read_data
    logic        m_axis_tuser;          // echo_valid
    logic        m_axis_tlast;          // last
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    echoing_line_receiver #(
        .LINE_DEPTH(DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // predictor state
    logic [7:0] line_mem [DEPTH];
    logic       line_mem_set [DEPTH];
    int         fill = 0;
    logic [8:0] cap_reg = 9'd256;
    t_word      echo_due [$];

    // typed expectation of the word being driven
    logic       plan_typed = 1'b0;
    t_event     plan_evt = EV_NONE;
    logic [7:0] plan_len = '0;

    logic       calm = 1'b0;
    int         errors = 0;
    int         items_sent = 0;
    int         words_seen = 0;
    int         events_seen [4] = '{0, 0, 0, 0};
    int         idle_cycles = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        for (int k = 0; k < DEPTH; k++) begin
            line_mem[k] = '0;
            line_mem_set[k] = 1'b0;
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready = calm || ($urandom_range(99) >= 29);
    end

    function automatic t_word echo_word(input logic [7:0] ch);
        return '{1'b1, ch, EV_NONE, 8'd0, 8'd0, 1'b0};
    endfunction

    function automatic void line_edit_step(input logic op, input logic [7:0] rxb,
                                           input logic [7:0] idx);
        t_word  words [5];
        int     n;
        int     lim;
        t_event ev;
        logic [7:0] len;
        if (op == OP_READ) begin
            echo_due.push_back('{1'b0, 8'd0, EV_NONE, 8'd0, line_mem[idx], 1'b1});
            return;
        end
        words[0] = echo_word(rxb);
        n = 1;
        ev = EV_NONE;
        len = '0;
        lim = (cap_reg == 9'd0) ? 1 : ((int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg));
        lim = lim - 1;
        if (rxb == CH_CR) begin
            words[1] = echo_word(CH_LF);
            n = 2;
            ev = EV_LINE;
        end else if (rxb == CH_BS) begin
            if (fill > 0) begin
                words[1] = echo_word(CH_SP);
                words[2] = echo_word(CH_BS);
                n = 3;
                fill--;
            end
        end else if (fill < lim) begin
            line_mem[fill] = rxb;
            line_mem_set[fill] = 1'b1;
            fill++;
            if (fill >= 6 && {line_mem[fill-6], line_mem[fill-5], line_mem[fill-4],
                              line_mem[fill-3], line_mem[fill-2], line_mem[fill-1]} == KEYWORD)
                ev = EV_KEYWORD;
        end else begin
            words[1] = echo_word(CH_CR);
            words[2] = echo_word(CH_LF);
            words[3] = echo_word(CH_LF);
            words[4] = echo_word(CH_LF);
            n = 5;
            ev = EV_OVERFLOW;
        end
        if (ev != EV_NONE) begin
            len = 8'(fill);
            fill = 0;
        end
        words[n-1].evt = plan_typed ? plan_evt : ev;
        words[n-1].line_len = plan_typed ? plan_len : len;
        words[n-1].last = 1'b1;
        for (int k = 0; k < n; k++)
            echo_due.push_back(words[k]);
    endfunction

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    task automatic check_word();
        t_word got;
        t_word want;
        got = '{m_axis_tuser, m_axis_tdata[7:0], t_event'(m_axis_tdata[9:8]),
                m_axis_tdata[17:10], m_axis_tdata[25:18], m_axis_tlast};
        words_seen++;
        if (echo_due.size() == 0) begin
            report($sformatf("unexpected output word %h", got));
        end else begin
            want = echo_due.pop_front();
            if (got !== want || m_axis_tdata[31:26] !== 6'd0)
                report($sformatf({"valid %b/%b byte %h/%h event %0d/%0d len %0d/%0d",
                                  " rd %h/%h last %b/%b pad %h"},
                                 got.echo_valid, want.echo_valid, got.out_byte, want.out_byte,
                                 got.evt, want.evt, got.line_len, want.line_len,
                                 got.read_data, want.read_data, got.last, want.last,
                                 m_axis_tdata[31:26]));
            else if (want.last)
                events_seen[want.evt]++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                line_edit_step(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8]);
            if (m_axis_tvalid && m_axis_tready)
                check_word();
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (psel && penable && pready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_MAX)
            @(posedge i_clk);
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_MAX);
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_word(input logic op, input logic [7:0] b, input logic [7:0] idx,
                             input logic typed, input t_event evt, input logic [7:0] len);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 29) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tuser = op;
        s_axis_tdata = {idx, b};
        plan_typed = typed;
        plan_evt = evt;
        plan_len = len;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic send_rx(input logic [7:0] b);
        send_word(OP_RX, b, 8'($urandom_range(255)), 1'b0, EV_NONE, 8'd0);
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (echo_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [8:0] cap);
        drain();
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = ADDR_LINE_CAP;
        pwdata = {23'd0, cap};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        cap_reg = cap;
        @(negedge i_clk);
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {23'd0, cap})
            report($sformatf("capacity readback %h, wrote %h", prdata, cap));
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    function automatic logic [7:0] content_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (b == CH_CR || b == CH_BS);
        return b;
    endfunction

    function automatic logic [7:0] pick_index();
        logic [7:0] idx;
        idx = 8'($urandom_range(255));
        for (int k = 0; k < DEPTH; k++) begin
            if (line_mem_set[idx])
                break;
            idx++;
        end
        return idx;
    endfunction

    initial begin
        logic [8:0] cap;
        int         round_end;
        int         pick;
        int         typo;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int r = 0; r < PLAN_LEN; r++) begin
            case (PLAN[r].kind)
                ROW_CAP:  set_capacity(PLAN[r].val);
                ROW_READ: send_word(OP_READ, PLAN[r].val[7:0], PLAN[r].idx, PLAN[r].typed,
                                    PLAN[r].evt, PLAN[r].len);
                default:  send_word(OP_RX, PLAN[r].val[7:0], PLAN[r].idx, PLAN[r].typed,
                                    PLAN[r].evt, PLAN[r].len);
            endcase
        end

        // long line with no idling on either side
        set_capacity(9'd256);
        calm = 1'b1;
        repeat (40) send_rx(content_byte());
        send_rx(CH_CR);
        calm = 1'b0;
        repeat (4) send_word(OP_READ, 8'($urandom_range(255)), pick_index(), 1'b0,
                             EV_NONE, 8'd0);

        for (int round = 0; round < 4; round++) begin
            case (round)
                0:       cap = 9'($urandom_range(3, 12));
                1:       cap = 9'd256;
                2:       cap = 9'($urandom_range(1, 6));
                default: cap = 9'h1FF;
            endcase
            set_capacity(cap);
            round_end = items_sent + 12;
            while (items_sent < round_end) begin
                pick = $urandom_range(99);
                if (pick < 30) begin
                    repeat ($urandom_range(0, 3)) send_rx(content_byte());
                    typo = $urandom_range(0, 11);
                    for (int j = 0; j < 6; j++) begin
                        if (j == typo) begin
                            send_rx(content_byte());
                            send_rx(CH_BS);
                        end
                        send_rx(KEYWORD[8*(5-j) +: 8]);
                    end
                end else if (pick < 65) begin
                    repeat ($urandom_range(0, 10)) begin
                        send_rx(content_byte());
                        if ($urandom_range(99) < 15)
                            send_rx(CH_BS);
                    end
                    send_rx(CH_CR);
                end else if (pick < 80) begin
                    send_word(OP_READ, 8'($urandom_range(255)), pick_index(), 1'b0,
                              EV_NONE, 8'd0);
                end else begin
                    send_rx(8'($urandom_range(255)));
                end
            end
        end

        drain();
        repeat (16) @(posedge i_clk);
        $display("sent %0d input words, checked %0d output words", items_sent, words_seen);
        $display("events: line end %0d, keyword %0d, overflow %0d",
                 events_seen[EV_LINE], events_seen[EV_KEYWORD], events_seen[EV_OVERFLOW]);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
